### src/lattice_checkerboard_site_index_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checkerboard site index unit
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LATTICE_CHECKERBOARD_SITE_INDEX_UNIT_ASSERT_SVH
`define LATTICE_CHECKERBOARD_SITE_INDEX_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LCSI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcsi assertion failed");

// Next-cycle implication.
`define LCSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcsi assertion failed");

`endif

### src/lcsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsi_pkg
// Shared constants for the checkerboard site index unit.
// ----------------------------------------------------------------------------
package lcsi_pkg;

  localparam int unsigned DIMS         = 4;
  localparam int unsigned LOCAL_BITS   = 24;
  localparam int unsigned CFG_IDX_BITS = 3;
  // divide steps folded into one pipeline stage
  localparam int unsigned DIV_STEPS    = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_LAT_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAT_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAT_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAT_T = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUB_X = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUB_Y = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUB_Z = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUB_T = 3'd7;

endpackage

### src/lcsi_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsi_in_if
// Input channel: one global site number per transaction.
// ----------------------------------------------------------------------------
interface lcsi_in_if #(
  parameter int unsigned POSITION_BITS = 28
) ();
  logic                     valid;
  logic                     ready;
  logic [POSITION_BITS-1:0] global_position;

  modport source (output valid, output global_position, input ready);
  modport sink   (input valid, input global_position, output ready);
endinterface

### src/lcsi_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsi_out_if
// Result channel: coordinates, parity and local checkerboard index.
// ----------------------------------------------------------------------------
interface lcsi_out_if #(
  parameter int unsigned EXTENT_BITS = 7
) ();
  logic                              valid;
  logic                              ready;
  logic [EXTENT_BITS-1:0]            coord_x;
  logic [EXTENT_BITS-1:0]            coord_y;
  logic [EXTENT_BITS-1:0]            coord_z;
  logic [EXTENT_BITS-1:0]            coord_t;
  logic                              parity;
  logic [lcsi_pkg::LOCAL_BITS-1:0]   local_index;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output coord_t, output parity, output local_index, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input coord_t, input parity, input local_index, output ready);
endinterface

### src/lcsi_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsi_div_stage
// A few restoring-division steps of one dimension, one register stage.
// ----------------------------------------------------------------------------
module lcsi_div_stage #(
  parameter int unsigned POSITION_BITS = 28,
  parameter int unsigned EXTENT_BITS   = 7,
  parameter int unsigned STEPS         = 4,
  parameter int unsigned DIM           = 0,
  parameter bit          LAST          = 1'b0
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           adv_i,
  input  logic                                           valid_i,
  input  logic [POSITION_BITS-1:0]                       work_i,
  input  logic [EXTENT_BITS-1:0]                         rem_i,
  input  logic [lcsi_pkg::DIMS-1:0][EXTENT_BITS-1:0]     coords_i,
  input  logic [EXTENT_BITS:0]                           divisor_i,
  output logic                                           valid_o,
  output logic [POSITION_BITS-1:0]                       work_o,
  output logic [EXTENT_BITS-1:0]                         rem_o,
  output logic [lcsi_pkg::DIMS-1:0][EXTENT_BITS-1:0]     coords_o
);

  logic                                       valid_q;
  logic [POSITION_BITS-1:0]                   work_d, work_q;
  logic [EXTENT_BITS-1:0]                     rem_d, rem_q;
  logic [lcsi_pkg::DIMS-1:0][EXTENT_BITS-1:0] coords_d, coords_q;

  // work register shifts dividend bits out at the top, quotient bits in at the bottom
  always_comb begin
    logic [EXTENT_BITS:0] trial;
    logic                 qbit;
    work_d   = work_i;
    rem_d    = rem_i;
    coords_d = coords_i;
    for (int unsigned s = 0; s < STEPS; s++) begin
      trial = {rem_d, work_d[POSITION_BITS-1]};
      qbit  = (trial >= divisor_i);
      if (qbit) begin
        trial = trial - divisor_i;
      end
      rem_d  = trial[EXTENT_BITS-1:0];
      work_d = {work_d[POSITION_BITS-2:0], qbit};
    end
    if (LAST) begin
      coords_d[DIM] = rem_d;
      rem_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      work_q   <= work_d;
      rem_q    <= rem_d;
      coords_q <= coords_d;
    end
  end

  assign valid_o  = valid_q;
  assign work_o   = work_q;
  assign rem_o    = rem_q;
  assign coords_o = coords_q;

endmodule

### src/lcsi_cb_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsi_cb_index
// Subgrid reduction and checkerboard index; last stage is the output register.
// ----------------------------------------------------------------------------
module lcsi_cb_index #(
  parameter int unsigned EXTENT_BITS = 7
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       adv_i,
  input  logic                                       valid_i,
  input  logic [lcsi_pkg::DIMS-1:0][EXTENT_BITS-1:0] coords_i,
  input  logic [lcsi_pkg::DIMS-1:0][EXTENT_BITS-1:0] sub_i,
  output logic                                       valid_o,
  output logic [lcsi_pkg::DIMS-1:0][EXTENT_BITS-1:0] coords_o,
  output logic                                       parity_o,
  output logic [lcsi_pkg::LOCAL_BITS-1:0]            local_index_o
);

  localparam int unsigned LB = lcsi_pkg::LOCAL_BITS;
  localparam int unsigned NS = 5;

  typedef logic [lcsi_pkg::DIMS-1:0][EXTENT_BITS-1:0] coord_vec_t;

  function automatic logic [EXTENT_BITS-1:0] mod_f(input logic [EXTENT_BITS-1:0] v,
                                                   input logic [EXTENT_BITS-1:0] s);
    logic [EXTENT_BITS-1:0] r;
    logic [EXTENT_BITS:0]   t;
    r = '0;
    for (int i = EXTENT_BITS - 1; i >= 0; i--) begin
      t = {r, v[i]};
      if (t >= {1'b0, s}) begin
        t = t - {1'b0, s};
      end
      r = t[EXTENT_BITS-1:0];
    end
    return r;
  endfunction

  logic [NS-1:0]          valid_q;
  coord_vec_t             coords_q [NS];
  logic [NS-1:0]          par_q;
  logic [EXTENT_BITS-1:0] cbc0_q [3];
  logic [EXTENT_BITS-1:0] cbc1_q [2];
  logic [EXTENT_BITS-1:0] cbc2_q, cbc3_q;
  logic [LB-1:0]          acc2_q, acc3_q, acc4_q, idx_q;
  logic [LB-1:0]          hv2_q, hv3_q, hv4_q;
  logic [LB-1:0]          acc2_d, acc3_d, acc4_d, idx_d, hv2_d, hv3_d, hv4_d;

  always_comb begin
    acc2_d = LB'(cbc2_q) + LB'(sub_i[2]) * LB'(cbc3_q);
    hv2_d  = LB'(sub_i[0]) * LB'(sub_i[1]);
    acc3_d = LB'(cbc1_q[1]) + LB'(sub_i[1]) * acc2_q;
    hv3_d  = hv2_q * LB'(sub_i[2]);
    acc4_d = LB'(cbc0_q[2]) + LB'(sub_i[0]) * acc3_q;
    hv4_d  = hv3_q * LB'(sub_i[3]);
    idx_d  = acc4_q + (par_q[3] ? hv4_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // stage 1: subgrid coordinates and parity
      coords_q[0] <= coords_i;
      par_q[0]    <= coords_i[0][0] ^ coords_i[1][0] ^ coords_i[2][0] ^ coords_i[3][0];
      cbc0_q[0]   <= mod_f(coords_i[0] >> 1, sub_i[0]);
      cbc1_q[0]   <= mod_f(coords_i[1], sub_i[1]);
      cbc2_q      <= mod_f(coords_i[2], sub_i[2]);
      cbc3_q      <= mod_f(coords_i[3], sub_i[3]);
      // stages 2-4: Horner chain and half volume
      for (int unsigned k = 1; k < NS; k++) begin
        coords_q[k] <= coords_q[k-1];
        par_q[k]    <= par_q[k-1];
      end
      cbc0_q[1] <= cbc0_q[0];
      cbc0_q[2] <= cbc0_q[1];
      cbc1_q[1] <= cbc1_q[0];
      acc2_q    <= acc2_d;
      hv2_q     <= hv2_d;
      acc3_q    <= acc3_d;
      hv3_q     <= hv3_d;
      acc4_q    <= acc4_d;
      hv4_q     <= hv4_d;
      // stage 5: odd sites go to the upper half
      idx_q     <= idx_d;
    end
  end

  assign valid_o       = valid_q[NS-1];
  assign coords_o      = coords_q[NS-1];
  assign parity_o      = par_q[NS-1];
  assign local_index_o = idx_q;

endmodule

### src/lattice_checkerboard_site_index_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_checkerboard_site_index_unit
// Global site number to 4-D coordinates, parity and even-odd local index.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries a global lexicographic site number (x fastest); one
//         transaction per clock when the result side keeps up.
//   out_o returns x/y/z/t coordinates, parity (sum of coordinates mod 2)
//         and the checkerboarded index inside the local subgrid.
//   cfg_*: plain register writes (lattice extents 0..3, subgrid extents
//         4..7); extents are clamped when written. Write only while idle.
// Pipeline: four chained dividers, one per dimension, each retiring four quotient
//   bits per stage, then subgrid modulo, three multiply stages and the
//   final add in the output register.
// Throughput: one transaction per cycle while out_o does not stall, set by
//   the fully pipelined divider chain.
// Reset: pipeline emptied, extents return to 16 (lattice) and 8 (subgrid).
// Stall: while a result sits in the output register and out_o.ready is
//   low, the whole pipeline freezes and in_i.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module lattice_checkerboard_site_index_unit #(
  parameter int unsigned EXTENT_BITS   = 7,
  parameter int unsigned POSITION_BITS = 28
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lcsi_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [EXTENT_BITS:0]              cfg_data_i,
  lcsi_in_if.sink                           in_i,
  lcsi_out_if.source                        out_o
);

  `include "lattice_checkerboard_site_index_unit_assert.svh"

  localparam int unsigned DIMS  = lcsi_pkg::DIMS;
  localparam int unsigned STP   = lcsi_pkg::DIV_STEPS;
  localparam int unsigned SPD   = (POSITION_BITS + STP - 1) / STP;  // stages per dimension
  localparam int unsigned NDIV  = DIMS * SPD;
  localparam int unsigned LSTEP = POSITION_BITS - STP * (SPD - 1);

  // clamp limits and reset values
  localparam int unsigned MAXL   = 1 << EXTENT_BITS;
  localparam int unsigned MAXSX  = 1 << (EXTENT_BITS - 2);
  localparam int unsigned MAXS   = 1 << (EXTENT_BITS - 1);
  localparam int unsigned LAT_RV = (16 > MAXL) ? MAXL : 16;
  localparam int unsigned SX_RV  = (4 > MAXSX) ? MAXSX : 4;
  localparam int unsigned S_RV   = (8 > MAXS) ? MAXS : 8;

  logic [DIMS-1:0][EXTENT_BITS:0]   lat_q;
  logic [DIMS-1:0][EXTENT_BITS-1:0] sub_q;
  logic [EXTENT_BITS:0]             lat_new;
  logic [EXTENT_BITS-1:0]           subx_raw, subx_new, sub_raw, sub_new;
  logic                             adv;

  // ---- configuration: store clamped extents --------------------------------
  always_comb begin
    lat_new = cfg_data_i;
    if (cfg_data_i == '0) begin
      lat_new = (EXTENT_BITS+1)'(1);
    end else if (cfg_data_i > (EXTENT_BITS+1)'(MAXL)) begin
      lat_new = (EXTENT_BITS+1)'(MAXL);
    end
    // x subgrid is stored halved
    subx_raw = cfg_data_i[EXTENT_BITS-1:0] >> 1;
    subx_new = subx_raw;
    if (subx_raw == '0) begin
      subx_new = EXTENT_BITS'(1);
    end else if (subx_raw > EXTENT_BITS'(MAXSX)) begin
      subx_new = EXTENT_BITS'(MAXSX);
    end
    sub_raw = cfg_data_i[EXTENT_BITS-1:0];
    sub_new = sub_raw;
    if (sub_raw == '0) begin
      sub_new = EXTENT_BITS'(1);
    end else if (sub_raw > EXTENT_BITS'(MAXS)) begin
      sub_new = EXTENT_BITS'(MAXS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned d = 0; d < DIMS; d++) begin
        lat_q[d] <= (EXTENT_BITS+1)'(LAT_RV);
      end
      sub_q[0] <= EXTENT_BITS'(SX_RV);
      for (int unsigned d = 1; d < DIMS; d++) begin
        sub_q[d] <= EXTENT_BITS'(S_RV);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcsi_pkg::REG_LAT_X: lat_q[0] <= lat_new;
        lcsi_pkg::REG_LAT_Y: lat_q[1] <= lat_new;
        lcsi_pkg::REG_LAT_Z: lat_q[2] <= lat_new;
        lcsi_pkg::REG_LAT_T: lat_q[3] <= lat_new;
        lcsi_pkg::REG_SUB_X: sub_q[0] <= subx_new;
        lcsi_pkg::REG_SUB_Y: sub_q[1] <= sub_new;
        lcsi_pkg::REG_SUB_Z: sub_q[2] <= sub_new;
        lcsi_pkg::REG_SUB_T: sub_q[3] <= sub_new;
        default: ;
      endcase
    end
  end

  // ---- flow control: everything moves unless the output is held ----------
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // ---- divider chain --------------------------------------------------------
  logic [NDIV:0]                    dv_valid;
  logic [POSITION_BITS-1:0]         dv_work   [NDIV+1];
  logic [EXTENT_BITS-1:0]           dv_rem    [NDIV+1];
  logic [DIMS-1:0][EXTENT_BITS-1:0] dv_coords [NDIV+1];

  assign dv_valid[0]  = in_i.valid;
  assign dv_work[0]   = in_i.global_position;
  assign dv_rem[0]    = '0;
  assign dv_coords[0] = '0;

  for (genvar d = 0; d < DIMS; d++) begin : g_dim
    for (genvar s = 0; s < SPD; s++) begin : g_stage
      lcsi_div_stage #(
        .POSITION_BITS (POSITION_BITS),
        .EXTENT_BITS   (EXTENT_BITS),
        .STEPS         ((s == SPD - 1) ? LSTEP : STP),
        .DIM           (d),
        .LAST          (s == SPD - 1)
      ) u_div (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .adv_i     (adv),
        .valid_i   (dv_valid[d*SPD+s]),
        .work_i    (dv_work[d*SPD+s]),
        .rem_i     (dv_rem[d*SPD+s]),
        .coords_i  (dv_coords[d*SPD+s]),
        .divisor_i (lat_q[d]),
        .valid_o   (dv_valid[d*SPD+s+1]),
        .work_o    (dv_work[d*SPD+s+1]),
        .rem_o     (dv_rem[d*SPD+s+1]),
        .coords_o  (dv_coords[d*SPD+s+1])
      );
    end
  end

  // ---- subgrid index and output register -----------------------------------
  logic [DIMS-1:0][EXTENT_BITS-1:0] out_coords;

  lcsi_cb_index #(
    .EXTENT_BITS (EXTENT_BITS)
  ) u_cb (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .valid_i       (dv_valid[NDIV]),
    .coords_i      (dv_coords[NDIV]),
    .sub_i         (sub_q),
    .valid_o       (out_o.valid),
    .coords_o      (out_coords),
    .parity_o      (out_o.parity),
    .local_index_o (out_o.local_index)
  );

  assign out_o.coord_x = out_coords[0];
  assign out_o.coord_y = out_coords[1];
  assign out_o.coord_z = out_coords[2];
  assign out_o.coord_t = out_coords[3];

  // dv_work at the chain end carries the dropped t quotient and dv_rem is zero; both unused.

  // ---- assertions ----------------------------------------------------------
  `LCSI_ASSERT_NOW(a_parity, out_o.valid, out_o.parity == (out_o.coord_x[0] ^ out_o.coord_y[0] ^ out_o.coord_z[0] ^ out_o.coord_t[0]))
  `LCSI_ASSERT_NOW(a_coord_x_range, out_o.valid, (EXTENT_BITS+1)'(out_o.coord_x) < lat_q[0])
  `LCSI_ASSERT_NOW(a_coord_t_range, out_o.valid, (EXTENT_BITS+1)'(out_o.coord_t) < lat_q[3])
  `LCSI_ASSERT_NOW(a_hold_input, out_o.valid && !out_o.ready, !in_i.ready)
  `LCSI_ASSERT_NEXT(a_enter, in_i.valid && in_i.ready, dv_valid[1])

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checkerboard site index unit: directed table
// of site numbers, then randomized traffic under several extent settings,
// with bursty input, receiver stalls and an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned EB = 7;
  localparam int unsigned PB = 28;
  localparam int unsigned LAT = 4 * ((PB + 3) / 4) + 5;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [EB-1:0] cx, cy, cz, ct;
    logic          par;
    logic [23:0]   lidx;
  } site_t;

  typedef struct {
    logic [PB-1:0] pos;
    logic          chk;   // typed expectation present
    site_t         want;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [lcsi_pkg::CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [EB:0] cfg_data_i;

  lcsi_in_if  #(.POSITION_BITS(PB)) in_if ();
  lcsi_out_if #(.EXTENT_BITS(EB))   out_if ();

  lattice_checkerboard_site_index_unit #(.EXTENT_BITS(EB), .POSITION_BITS(PB)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_if.sink), .out_o(out_if.source)
  );

  // Shadow copy of the extent registers: lattice values raw as written, subgrid values masked to seven bits.
  int unsigned lat_ext [4];
  int unsigned sub_ext [4];
  site_t       pending_sites [$];
  site_t       typed_sites [$];  // declared but unused
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off = 0;
  bit          stall_rand = 1;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Predictor: global number -> coordinates, parity, checkerboard index.
  function automatic site_t predict_site(logic [PB-1:0] pos_in);
    longint unsigned p, half_vol, ord;
    int unsigned e, crd [4], sb [4], cbc [4], sum;
    site_t s;
    p = pos_in;
    sum = 0;
    for (int d = 0; d < 4; d++) begin
      e = lat_ext[d] == 0 ? 1 : (lat_ext[d] > 128 ? 128 : lat_ext[d]);
      crd[d] = p % e;
      p = p / e;
      sum += crd[d];
    end
    sb[0] = (sub_ext[0] >> 1) == 0 ? 1 : ((sub_ext[0] >> 1) > 32 ? 32 : sub_ext[0] >> 1);
    for (int d = 1; d < 4; d++)
      sb[d] = sub_ext[d] == 0 ? 1 : (sub_ext[d] > 64 ? 64 : sub_ext[d]);
    cbc[0] = (crd[0] >> 1) % sb[0];
    for (int d = 1; d < 4; d++) cbc[d] = crd[d] % sb[d];
    half_vol = longint'(sb[0]) * sb[1] * sb[2] * sb[3];
    ord = 0;
    for (int d = 3; d >= 1; d--) ord = sb[d-1] * (cbc[d] + ord);
    ord += cbc[0] + (sum & 1) * half_vol;
    s.cx = crd[0][EB-1:0];
    s.cy = crd[1][EB-1:0];
    s.cz = crd[2][EB-1:0];
    s.ct = crd[3][EB-1:0];
    s.par = sum[0];
    s.lidx = ord[23:0];
    return s;
  endfunction

  task automatic write_reg(logic [lcsi_pkg::CFG_IDX_BITS-1:0] idx, logic [EB:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < lcsi_pkg::DIMS) lat_ext[idx] = val;
    else sub_ext[idx-lcsi_pkg::DIMS] = val & 8'h7f;
  endtask

  task automatic set_extents(int unsigned lx, ly, lz, lt, sx, sy, sz, st);
    write_reg(lcsi_pkg::REG_LAT_X, lx[EB:0]);
    write_reg(lcsi_pkg::REG_LAT_Y, ly[EB:0]);
    write_reg(lcsi_pkg::REG_LAT_Z, lz[EB:0]);
    write_reg(lcsi_pkg::REG_LAT_T, lt[EB:0]);
    write_reg(lcsi_pkg::REG_SUB_X, sx[EB:0]);
    write_reg(lcsi_pkg::REG_SUB_Y, sy[EB:0]);
    write_reg(lcsi_pkg::REG_SUB_Z, sz[EB:0]);
    write_reg(lcsi_pkg::REG_SUB_T, st[EB:0]);
  endtask

  // Offer one site number and hold it until the transaction completes.
  // valid stays high between back-to-back transactions.
  task automatic send_site(logic [PB-1:0] pos, logic chk, site_t want);
    in_if.valid <= 1'b1;
    in_if.global_position <= pos;
    do @(posedge clk_i); while (!in_if.ready);
    pending_sites.push_back(chk ? want : predict_site(pos));
    @(negedge clk_i);
  endtask

  task automatic pause_input(int unsigned n);
    in_if.valid <= 1'b0;
    in_if.global_position <= PB'($urandom);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending_sites.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_burst(int unsigned n_items, bit small_pos);
    int unsigned left, burst;
    site_t dummy;
    logic [PB-1:0] pos;
    dummy = '0;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++) begin
        pos = PB'($urandom);
        if (small_pos && $urandom_range(0, 1)) pos = pos % 300000;
        send_site(pos, 1'b0, dummy);
      end
      left -= burst;
      if ($urandom_range(0, 3) == 0) pause_input($urandom_range(1, 12));
    end
  endtask

  // Result check: compare each transaction with the oldest expectation.
  always @(posedge clk_i) begin
    site_t got, exp_s;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.coord_x, out_if.coord_y, out_if.coord_z, out_if.coord_t,
              out_if.parity, out_if.local_index};
      if (pending_sites.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp_s = pending_sites.pop_front();
        if (got !== exp_s) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_s, got);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  initial begin
    int unsigned ph;
    out_if.ready = 1'b0;
    ph = 0;
    forever begin
      @(negedge clk_i);
      ph++;
      if (hold_off) out_if.ready <= 1'b0;
      else if (!stall_rand) out_if.ready <= 1'b1;
      else out_if.ready <= ((ph % 7) < 5) && ($urandom_range(0, 4) != 0);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t tbl [$];
    row_t r;
    site_t dummy;
    dummy = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.global_position = '0;
    for (int d = 0; d < 4; d++) begin
      lat_ext[d] = 16;
      sub_ext[d] = 8;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table with reset extents (16^4 lattice, 8^4 subgrid).
    tbl.push_back('{PB'(0), 1'b1, '{7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 24'd0}});
    tbl.push_back('{PB'(1), 1'b1, '{7'd1, 7'd0, 7'd0, 7'd0, 1'b1, 24'd2048}});
    tbl.push_back('{PB'(16), 1'b1, '{7'd0, 7'd1, 7'd0, 7'd0, 1'b1, 24'd2052}});
    tbl.push_back('{PB'(65535), 1'b1, '{7'd15, 7'd15, 7'd15, 7'd15, 1'b0, 24'd2047}});
    // beyond the lattice volume: wraps
    tbl.push_back('{PB'(65536), 1'b1, '{7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 24'd0}});
    tbl.push_back('{{PB{1'b1}}, 1'b0, dummy});
    tbl.push_back('{PB'(28'h5555555), 1'b0, dummy});
    tbl.push_back('{PB'(28'hAAAAAAA), 1'b0, dummy});
    tbl.push_back('{PB'(12345), 1'b0, dummy});
    foreach (tbl[i]) send_site(tbl[i].pos, tbl[i].chk, tbl[i].want);
    drain;

    // Smallest extents, including zero and sub x below 2.
    set_extents(0, 1, 0, 1, 1, 0, 1, 0);
    for (int i = 0; i < 6; i++)
      send_site(PB'($urandom), 1'b1, '{7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 24'd0});
    drain;

    // Largest extents and saturation above the limits.
    set_extents(128, 255, 200, 128, 127, 64, 127, 100);
    send_site({PB{1'b1}}, 1'b0, dummy);
    send_site(PB'(127), 1'b0, dummy);
    send_site(PB'(128*128*128 - 1), 1'b0, dummy);
    random_burst(300, 1'b0);

    // Long receiver hold-off while input keeps coming.
    hold_off = 1;
    fork
      begin repeat (LAT + 60) @(negedge clk_i); hold_off = 0; end
      random_burst(80, 1'b0);
    join
    drain;

    for (int ph = 0; ph < 4; ph++) begin
      set_extents($urandom_range(1, 128), $urandom_range(1, 128), $urandom_range(1, 20),
                  $urandom_range(1, 128), $urandom_range(2, 64), $urandom_range(1, 64),
                  $urandom_range(1, 64), $urandom_range(1, 64));
      stall_rand = (ph != 2);
      random_burst(200, 1'b1);
      drain;
    end
    stall_rand = 1;
    set_extents(3, 5, 7, 2, 6, 3, 2, 5);
    random_burst(250, 1'b1);
    drain;
    set_extents(16, 16, 16, 16, 8, 8, 8, 8);
    random_burst(150, 1'b1);

    in_if.valid <= 1'b0;
    while (pending_sites.size() != 0) @(negedge clk_i);
    repeat (LAT + 10) @(negedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
